/* sv/twms_pkg.sv */
// Shared types and constants for the timed window mode sequencer.
// Used by every module of the block; depends on nothing else.
package twms_pkg;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_ARM    = 2'd1,
      CMD_DISARM = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PH_STANDBY = 2'd0,
      PH_BEFORE  = 2'd1,
      PH_READY   = 2'd2,
      PH_RUNNING = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      REG_START_OFFSET = 2'd0,
      REG_END_OFFSET   = 2'd1,
      REG_PREP_LEAD    = 2'd2
   } reg_index_type;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [16:0] START_OFFSET_RESET = 17'd0;
   localparam logic [16:0] END_OFFSET_RESET   = 17'd3600;
   localparam logic [15:0] PREP_LEAD_RESET    = 16'd60;

   typedef struct packed {
      logic [16:0] start_offset;
      logic [16:0] end_offset;
      logic [15:0] prep_lead;
   } cfg_type;

   // One word after the midnight floor and the window sums.
   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] current_time;
      logic [31:0] win_start;
      logic [31:0] win_end;
      logic [31:0] win_end_day;
   } win_type;

   typedef struct packed {
      phase_type phase;
      logic      armed;
      logic      start_cycle;
      logic      stop_cycle;
      logic      prepare_request;
      logic      fault;
   } rsp_type;

endpackage

/* sv/twms_csr.sv */
// Configuration registers behind an APB-style port.
// Depends on twms_pkg for register indexes, reset values and cfg_type.
module twms_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [twms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [twms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [twms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output twms_pkg::cfg_type                 cfg
);
   import twms_pkg::*;

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_offset <= START_OFFSET_RESET;
         cfg_ff.end_offset   <= END_OFFSET_RESET;
         cfg_ff.prep_lead    <= PREP_LEAD_RESET;
      end else if (wr_en) begin
         unique case (index)
            REG_START_OFFSET: cfg_ff.start_offset <= csr_pwdata[16:0];
            REG_END_OFFSET:   cfg_ff.end_offset   <= csr_pwdata[16:0];
            REG_PREP_LEAD:    cfg_ff.prep_lead    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_START_OFFSET: csr_prdata = {15'd0, cfg_ff.start_offset};
         REG_END_OFFSET:   csr_prdata = {15'd0, cfg_ff.end_offset};
         REG_PREP_LEAD:    csr_prdata = {16'd0, cfg_ff.prep_lead};
         default:          csr_prdata = '0;
      endcase
   end

endmodule

/* sv/twms_window.sv */
// Input register and the state-free front pipeline: floor to midnight by
// reciprocal multiply with one correction, then the absolute window sums.
// Depends on twms_pkg for win_type and cfg_type.
module twms_window #(
   parameter int unsigned DAY_SECONDS = 86400
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_command,
   input  logic [31:0]       in_time,
   input  twms_pkg::cfg_type cfg,
   output logic              out_valid,
   input  logic              out_ready,
   output twms_pkg::win_type out_win
);
   import twms_pkg::*;

   // floor(2^32 / DAY_SECONDS); the estimate below is short by at most one day.
   localparam logic [32:0] Recip   = 33'((64'd1 << 32) / DAY_SECONDS);
   localparam logic [31:0] DaySec  = 32'(DAY_SECONDS);

   // Stage 1: input register.
   logic        v1_ff;
   logic [1:0]  cmd1_ff;
   logic [31:0] t1_ff;
   // Stage 2: quotient estimate.
   logic        v2_ff;
   logic [1:0]  cmd2_ff;
   logic [31:0] t2_ff, q2_ff, q2_in;
   // Stage 3: quotient times day length.
   logic        v3_ff;
   logic [1:0]  cmd3_ff;
   logic [31:0] t3_ff, prod3_ff, prod3_in;
   // Stage 4: corrected midnight.
   logic        v4_ff;
   logic [1:0]  cmd4_ff;
   logic [31:0] t4_ff, mid4_ff, mid4_in;
   // Stage 5: window sums.
   logic        v5_ff;
   win_type     win5_ff, win5_in;

   logic        en1, en2, en3, en4, en5;
   logic [64:0] recip_prod;
   logic [63:0] day_prod;
   logic [31:0] rem;

   assign en5      = !v5_ff || out_ready;
   assign en4      = !v4_ff || en5;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign recip_prod = 65'(t1_ff) * 65'(Recip);
   assign q2_in      = recip_prod[63:32];

   assign day_prod   = 64'(q2_ff) * 64'(DaySec);
   assign prod3_in   = day_prod[31:0];

   assign rem        = t3_ff - prod3_ff;
   assign mid4_in    = (rem >= DaySec) ? (prod3_ff + DaySec) : prod3_ff;

   always_comb begin
      win5_in.command      = cmd4_ff;
      win5_in.current_time = t4_ff;
      win5_in.win_start    = mid4_ff + 32'(cfg.start_offset);
      win5_in.win_end      = mid4_ff + 32'(cfg.end_offset);
      win5_in.win_end_day  = mid4_ff + 32'(cfg.end_offset) + DaySec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         cmd1_ff <= in_command;
         t1_ff   <= in_time;
      end
      if (en2) begin
         cmd2_ff <= cmd1_ff;
         t2_ff   <= t1_ff;
         q2_ff   <= q2_in;
      end
      if (en3) begin
         cmd3_ff  <= cmd2_ff;
         t3_ff    <= t2_ff;
         prod3_ff <= prod3_in;
      end
      if (en4) begin
         cmd4_ff <= cmd3_ff;
         t4_ff   <= t3_ff;
         mid4_ff <= mid4_in;
      end
      if (en5) begin
         win5_ff <= win5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_win   = win5_ff;

endmodule

/* sv/twms_phase.sv */
// Schedule state (armed flag, phase, window) and the result register.
// Depends on twms_pkg for command and phase codes and the word types.
module twms_phase (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  twms_pkg::win_type in_win,
   input  twms_pkg::cfg_type cfg,
   output logic              out_valid,
   input  logic              out_ready,
   output twms_pkg::rsp_type out_rsp
);
   import twms_pkg::*;

   logic        armed_ff, armed_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] ws_ff, ws_in;
   logic [31:0] we_ff, we_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        en, fire;
   logic [31:0] prep_point, we_arm;
   phase_type   expected;
   cmd_type     cmd;

   assign en       = !rsp_valid_ff || out_ready;
   assign fire     = in_valid && en;
   assign in_ready = en;
   assign cmd      = cmd_type'(in_win.command);

   // The preparation point follows the lead as currently configured.
   assign prep_point = ws_ff - 32'(cfg.prep_lead);
   assign we_arm     = (in_win.win_end <= in_win.win_start) ? in_win.win_end_day
                                                            : in_win.win_end;

   always_comb begin
      if (in_win.current_time < prep_point) begin
         expected = PH_BEFORE;
      end else if (in_win.current_time < ws_ff) begin
         expected = PH_READY;
      end else if (in_win.current_time < we_ff) begin
         expected = PH_RUNNING;
      end else begin
         expected = PH_STANDBY;
      end
   end

   always_comb begin
      armed_in = armed_ff;
      phase_in = phase_ff;
      ws_in    = ws_ff;
      we_in    = we_ff;
      rsp_in.start_cycle     = 1'b0;
      rsp_in.stop_cycle      = 1'b0;
      rsp_in.prepare_request = 1'b0;
      rsp_in.fault           = 1'b0;
      unique case (cmd)
         CMD_ARM: begin
            ws_in             = in_win.win_start;
            we_in             = we_arm;
            rsp_in.fault      = (in_win.win_start >= we_arm);
            armed_in          = 1'b1;
            phase_in          = PH_BEFORE;
            rsp_in.stop_cycle = 1'b1;
         end
         CMD_DISARM: begin
            armed_in          = 1'b0;
            phase_in          = PH_STANDBY;
            rsp_in.stop_cycle = 1'b1;
         end
         CMD_TICK: begin
            if (armed_ff && (expected != phase_ff)) begin
               phase_in = expected;
               case (expected)
                  PH_READY:   rsp_in.prepare_request = 1'b1;
                  PH_RUNNING: rsp_in.start_cycle     = 1'b1;
                  default:    rsp_in.stop_cycle      = 1'b1;
               endcase
            end
         end
         default: ;
      endcase
      rsp_in.phase = phase_in;
      rsp_in.armed = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         phase_ff     <= PH_STANDBY;
         ws_ff        <= '0;
         we_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            armed_ff <= armed_in;
            phase_ff <= phase_in;
            ws_ff    <= ws_in;
            we_ff    <= we_in;
         end
         if (en) rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

`ifndef SYNTH
   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_ff.start_cycle, rsp_ff.stop_cycle,
                                 rsp_ff.prepare_request}))
      else $error("more than one pulse in a result word");

   a_fault_on_arm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.fault |->
         rsp_ff.stop_cycle && rsp_ff.armed && (rsp_ff.phase == PH_BEFORE))
      else $error("fault outside an arm result");

   a_disarmed_standby: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (phase_ff == PH_STANDBY))
      else $error("phase left standby while disarmed");

   a_start_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.start_cycle |-> (rsp_ff.phase == PH_RUNNING))
      else $error("start pulse without running phase");

   a_disarm_clears: assert property (@(posedge clock) disable iff (reset)
      fire && (cmd == CMD_DISARM) |=> !armed_ff)
      else $error("disarm did not clear the armed flag");
`endif

endmodule

/* sv/timed_window_mode_sequencer_core.sv */
// Top level of the timed window mode sequencer: configuration registers,
// midnight and window front pipeline, and the phase state with result register.
// Depends on twms_pkg, twms_csr, twms_window and twms_phase.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_tvalid/tready    | tuser command, tdata current_time
//   rsp     | out       | rsp_tvalid/tready    | tdata phase and pulse flags
//   csr     | in/out    | psel/penable, pready | 3 registers at 0x0, 0x4, 0x8
//
// One word is accepted per cycle into the input register while req_tready is
// high; its result word then passes the quotient estimate, day multiply,
// correction and window sums, then the phase update into the result register.
// Reset is synchronous; no clearing pass follows it.
// A stalled result holds its word; earlier stages keep filling until full.
module timed_window_mode_sequencer_core #(
   parameter int unsigned DAY_SECONDS = 86400
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // [31:0] current_time
   input  logic [1:0]                        req_tuser,   // [1:0] command
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] phase, [2] armed, [3] start_cycle, [4] stop_cycle,
   // [5] prepare_request, [6] fault, [7] zero
   output logic [7:0]                        rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [twms_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [twms_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [twms_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import twms_pkg::*;

   cfg_type cfg;
   win_type win;
   rsp_type rsp;
   logic    win_valid, win_ready;

   twms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   twms_window #(
      .DAY_SECONDS (DAY_SECONDS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_command (req_tuser),
      .in_time    (req_tdata),
      .cfg        (cfg),
      .out_valid  (win_valid),
      .out_ready  (win_ready),
      .out_win    (win)
   );

   twms_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .in_ready  (win_ready),
      .in_win    (win),
      .cfg       (cfg),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.fault, rsp.prepare_request, rsp.stop_cycle,
                       rsp.start_cycle, rsp.armed, rsp.phase};

endmodule
